FILE: rtl/mle_behaviour_importance_weights_assert.svh
// assertion macros used by the checker file
`ifndef MLE_BEHAVIOUR_IMPORTANCE_WEIGHTS_ASSERT_SVH
`define MLE_BEHAVIOUR_IMPORTANCE_WEIGHTS_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define MBIW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mbiw assertion failed");

// next-cycle implication
`define MBIW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mbiw assertion failed");

`endif

FILE: rtl/mbiw_pkg.sv
// ----------------------------------------------------------------------------
// mbiw_pkg
// types, constants and command/status structs for the importance weight block
// ----------------------------------------------------------------------------
package mbiw_pkg;

	localparam int NUM_STATES_DEF  = 64;
	localparam int NUM_ACTIONS_DEF = 4;
	localparam int COUNT_BITS_DEF  = 32;

	localparam int STATE_W  = 6;
	localparam int ACTION_W = 2;
	localparam int PROB_W   = 17;
	localparam int SMOOTH_W = 8;
	localparam int WEIGHT_W = 32;
	localparam int DIV_STEPS = 32;

	localparam logic [WEIGHT_W-1:0] W_MAX = '1;
	localparam logic [WEIGHT_W-1:0] Q_ONE = 32'h0001_0000;

	localparam logic REQ_COUNT = 1'b0;
	localparam logic REQ_WEIGH = 1'b1;

	localparam logic [1:0] REG_SMOOTHING = 2'd0;

	typedef struct packed {
		logic                req_type;
		logic [STATE_W-1:0]  state_index;
		logic [ACTION_W-1:0] action_index;
		logic [PROB_W-1:0]   eval_prob;
		logic                first_step;
	} in_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] step_weight;
		logic [WEIGHT_W-1:0] running_weight;
		logic                saturated;
		logic                zero_estimate;
	} res_t;

	typedef struct packed {
		logic clr_step;
		logic cnt_wr;
		logic ld_nd;
		logic ld_mul;
		logic chk;
		logic div_step;
		logic div_last;
		logic ld_rmul;
		logic ld_out;
	} dp_cmd_t;

	typedef struct packed {
		logic is_weigh;
		logic skip;
		logic clr_last;
	} dp_sts_t;

endpackage

FILE: rtl/mle_behaviour_importance_weights.sv
// ----------------------------------------------------------------------------
// mle_behaviour_importance_weights
// importance weights against a laplace smoothed count estimate of behaviour
// ----------------------------------------------------------------------------
// channel  | handshake             | beat
// request  | start / busy          | req (in_t)
// result   | done strobe, no stall | result (res_t)
// config   | apb psel/penable      | pwdata[7:0] smoothing at paddr 0
//
// after reset a clearing pass zeroes the count memories, busy is high meanwhile.
// a count item reads the memories, then does the read-modify-write.
// a weigh item runs the 32-step restoring divider, which is skipped when the
// estimate is zero or the quotient overflows.
// the result strobe is high in the first cycle that busy is low; it cannot be stalled.
// ----------------------------------------------------------------------------
module mle_behaviour_importance_weights import mbiw_pkg::*; #(
	parameter int NUM_STATES  = NUM_STATES_DEF,
	parameter int NUM_ACTIONS = NUM_ACTIONS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_t         req,
	output logic        done,
	output res_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [SMOOTH_W-1:0] smooth_q;
	logic    ld_in;
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_SMOOTHING) ? {24'd0, smooth_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
		end else if (psel && penable && pwrite && paddr == REG_SMOOTHING) begin
			smooth_q <= pwdata[SMOOTH_W-1:0];
		end
	end

	mbiw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.ld_in(ld_in), .cmd(cmd), .sts(sts)
	);

	mbiw_dp #(
		.NUM_STATES(NUM_STATES), .NUM_ACTIONS(NUM_ACTIONS), .COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .ld_in(ld_in),
		.smoothing(smooth_q), .cmd(cmd), .sts(sts),
		.result(result), .done(done)
	);

endmodule

FILE: rtl/mbiw_ram.sv
// ----------------------------------------------------------------------------
// mbiw_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module mbiw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/mbiw_ctrl.sv
// ----------------------------------------------------------------------------
// mbiw_ctrl
// sequencer: clearing pass, count update, weigh step with iterative divide
// ----------------------------------------------------------------------------
module mbiw_ctrl import mbiw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output logic    ld_in,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	localparam int DCW = $clog2(DIV_STEPS);

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_RD, ST_USE, ST_MUL, ST_CHK, ST_DIV, ST_RMUL, ST_OUT
	} state_t;

	state_t         state_q;
	logic [DCW-1:0] dcnt_q;

	assign busy  = (state_q != ST_IDLE);
	assign ld_in = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			dcnt_q  <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_USE;
				ST_USE: begin
					state_q <= sts.is_weigh ? ST_MUL : ST_IDLE;
				end
				ST_MUL: state_q <= ST_CHK;
				ST_CHK: begin
					dcnt_q  <= '0;
					state_q <= sts.skip ? ST_RMUL : ST_DIV;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCW'(DIV_STEPS - 1)) state_q <= ST_RMUL;
				end
				ST_RMUL: state_q <= ST_OUT;
				ST_OUT:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.clr_step = (state_q == ST_CLR);
		cmd.cnt_wr   = (state_q == ST_USE) & ~sts.is_weigh;
		cmd.ld_nd    = (state_q == ST_USE);
		cmd.ld_mul   = (state_q == ST_MUL);
		cmd.chk      = (state_q == ST_CHK);
		cmd.div_step = (state_q == ST_DIV);
		cmd.div_last = (state_q == ST_DIV) & (dcnt_q == DCW'(DIV_STEPS - 1));
		cmd.ld_rmul  = (state_q == ST_RMUL);
		cmd.ld_out   = (state_q == ST_OUT);
	end

endmodule

FILE: rtl/mbiw_dp.sv
// ----------------------------------------------------------------------------
// mbiw_dp
// count memories, smoothed estimate, restoring divider and product register
// ----------------------------------------------------------------------------
module mbiw_dp import mbiw_pkg::*; #(
	parameter int NUM_STATES  = NUM_STATES_DEF,
	parameter int NUM_ACTIONS = NUM_ACTIONS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  in_t                 req,
	input  logic                ld_in,
	input  logic [SMOOTH_W-1:0] smoothing,
	input  dp_cmd_t             cmd,
	output dp_sts_t             sts,
	output res_t                result,
	output logic                done
);

	localparam int PD   = NUM_STATES * NUM_ACTIONS;
	localparam int PAW  = $clog2(PD);
	localparam int SW   = $clog2(NUM_STATES);
	localparam int AW   = $clog2(NUM_ACTIONS);
	localparam int CW   = COUNT_BITS;
	localparam int NUMW = CW + 1;
	localparam int DENW = ((CW > SMOOTH_W + AW) ? CW : SMOOTH_W + AW) + 1;
	localparam int PW   = PROB_W + DENW;
	localparam logic [CW-1:0] CNT_MAX = '1;

	in_t                 in_q;
	logic                valid_q;
	logic [PAW-1:0]      clr_q;
	logic [CW-1:0]       pc_rd, tc_rd;
	logic [NUMW-1:0]     num_q, rem_q;
	logic [DENW-1:0]     den_q;
	logic [PW-1:0]       prod_q;
	logic [WEIGHT_W-1:0] lo_q, step_q, psf_q;
	logic [2*WEIGHT_W-1:0] rprod_q;
	logic                sat_q, zero_q;
	res_t                res_q;
	logic                done_q;

	logic [PAW-1:0]  pair_addr, waddr_p;
	logic [SW-1:0]   st_addr, waddr_s;
	logic            we_p, we_s, cnt_we;
	logic [CW-1:0]   wdata_p, wdata_s, pcv, tcv;
	logic [PW-1:0]   hi;
	logic            is_zero, ovf;
	logic [NUMW:0]   rem2, rem_n;
	logic            ge, runsat;
	logic [WEIGHT_W-1:0] run;

	assign pair_addr = PAW'(32'(in_q.state_index) * 32'(NUM_ACTIONS) + 32'(in_q.action_index));
	assign st_addr   = SW'(in_q.state_index);
	assign cnt_we    = cmd.cnt_wr & valid_q;

	assign we_p    = cmd.clr_step | cnt_we;
	assign waddr_p = cmd.clr_step ? clr_q : pair_addr;
	assign wdata_p = cmd.clr_step ? '0 : ((pc_rd == CNT_MAX) ? pc_rd : pc_rd + 1'b1);
	assign we_s    = (cmd.clr_step & (32'(clr_q) < 32'(NUM_STATES))) | cnt_we;
	assign waddr_s = cmd.clr_step ? SW'(clr_q) : st_addr;
	assign wdata_s = cmd.clr_step ? '0 : ((tc_rd == CNT_MAX) ? tc_rd : tc_rd + 1'b1);

	mbiw_ram #(.WIDTH(CW), .DEPTH(PD)) u_pair_ram (
		.clk(clk), .we(we_p), .waddr(waddr_p), .wdata(wdata_p),
		.raddr(pair_addr), .rdata(pc_rd)
	);

	mbiw_ram #(.WIDTH(CW), .DEPTH(NUM_STATES)) u_total_ram (
		.clk(clk), .we(we_s), .waddr(waddr_s), .wdata(wdata_s),
		.raddr(st_addr), .rdata(tc_rd)
	);

	assign pcv = valid_q ? pc_rd : '0;
	assign tcv = valid_q ? tc_rd : '0;

	// upper part of the dividend; at or above num the quotient overflows 32 bits
	assign hi      = PW'({32'd0, prod_q} >> WEIGHT_W);
	assign is_zero = (num_q == '0);
	assign ovf     = (PW'(num_q) <= hi);

	assign rem2  = {rem_q, lo_q[WEIGHT_W-1]};
	assign ge    = (rem2 >= {1'b0, num_q});
	assign rem_n = ge ? (rem2 - {1'b0, num_q}) : rem2;

	assign runsat = |rprod_q[2*WEIGHT_W-1:WEIGHT_W+16];
	assign run    = in_q.first_step ? step_q :
		(runsat ? W_MAX : rprod_q[WEIGHT_W+15:16]);

	assign sts.is_weigh = (in_q.req_type == REQ_WEIGH);
	assign sts.skip     = is_zero | ovf;
	assign sts.clr_last = (clr_q == PAW'(PD - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			psf_q  <= Q_ONE;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.ld_out;
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.ld_out)   psf_q <= run;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_in) begin
			in_q    <= req;
			valid_q <= (32'(req.state_index) < 32'(NUM_STATES)) &&
				(32'(req.action_index) < 32'(NUM_ACTIONS));
		end
		if (cmd.ld_nd) begin
			num_q <= NUMW'(pcv) + NUMW'(smoothing);
			den_q <= DENW'(tcv) + DENW'(32'(smoothing) * 32'(NUM_ACTIONS));
		end
		if (cmd.ld_mul) prod_q <= PW'(in_q.eval_prob) * PW'(den_q);
		if (cmd.chk) begin
			rem_q  <= NUMW'(hi);
			lo_q   <= prod_q[WEIGHT_W-1:0];
			zero_q <= is_zero;
			if (is_zero) begin
				step_q <= (in_q.eval_prob != '0) ? W_MAX : '0;
				sat_q  <= (in_q.eval_prob != '0);
			end else if (ovf) begin
				step_q <= W_MAX;
				sat_q  <= 1'b1;
			end else begin
				sat_q <= 1'b0;
			end
		end
		if (cmd.div_step) begin
			rem_q <= NUMW'(rem_n);
			lo_q  <= {lo_q[WEIGHT_W-2:0], ge};
			if (cmd.div_last) step_q <= {lo_q[WEIGHT_W-2:0], ge};
		end
		if (cmd.ld_rmul) rprod_q <= (2*WEIGHT_W)'(psf_q) * (2*WEIGHT_W)'(step_q);
		if (cmd.ld_out) begin
			res_q.step_weight    <= step_q;
			res_q.running_weight <= run;
			res_q.saturated      <= sat_q | (~in_q.first_step & runsat);
			res_q.zero_estimate  <= zero_q;
		end
	end

	assign result = res_q;
	assign done   = done_q;

endmodule

FILE: rtl/mbiw_checker.sv
// ----------------------------------------------------------------------------
// mbiw_checker
// port-level checks on the request/result sequencing and saturation flag of the top level
// ----------------------------------------------------------------------------
`include "mle_behaviour_importance_weights_assert.svh"

module mbiw_checker import mbiw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input res_t result
);

	`MBIW_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`MBIW_ASSERT_NOW(a_done_after_busy, done, $past(busy) && !busy)
	`MBIW_ASSERT_NEXT(a_done_single, done, !done)
	`MBIW_ASSERT_NOW(a_zero_sat, done && result.zero_estimate && result.step_weight != 0,
		result.saturated)

endmodule

bind mle_behaviour_importance_weights mbiw_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .result(result)
);
